// ----- hdl/billboard_corner_expander_defines.svh -----
// Assertion macros for the billboard corner expander.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BILLBOARD_CORNER_EXPANDER_DEFINES_SVH
`define BILLBOARD_CORNER_EXPANDER_DEFINES_SVH

`ifndef SYNTHESIS
`define BCE_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("billboard_corner_expander check failed");
`define BCE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("billboard_corner_expander check failed");
`else
`define BCE_ASSERT(label, cond)
`define BCE_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ----- hdl/bce_pkg.sv -----
`timescale 1ns / 1ps
package bce_pkg;

  localparam int COORD_W    = 32;
  localparam int VEC_W      = 16;
  localparam int SIZE_W     = 16;
  localparam int OFF_W      = 25;
  localparam int SUM_W      = 34;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CORNER_W   = 2;
  localparam int S_DATA_W   = 3 * COORD_W;
  localparam int M_DATA_W   = 3 * COORD_W;
  localparam int M_USER_W   = CORNER_W + 1;

  localparam logic signed [VEC_W-1:0] RIGHT_X_RST = 16'sd16384;
  localparam logic signed [VEC_W-1:0] RIGHT_Y_RST = 16'sd0;
  localparam logic signed [VEC_W-1:0] RIGHT_Z_RST = 16'sd0;
  localparam logic signed [VEC_W-1:0] UP_X_RST    = 16'sd0;
  localparam logic signed [VEC_W-1:0] UP_Y_RST    = 16'sd16384;
  localparam logic signed [VEC_W-1:0] UP_Z_RST    = 16'sd0;
  localparam logic [2*SIZE_W-1:0]     QUAD_SIZE_RST = '0;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RIGHT_X     = 8'd0,
    REG_RIGHT_Y     = 8'd1,
    REG_RIGHT_Z     = 8'd2,
    REG_UP_X        = 8'd3,
    REG_UP_Y        = 8'd4,
    REG_UP_Z        = 8'd5,
    REG_QUAD_SIZE   = 8'd6,
    REG_FACING_MODE = 8'd7
  } cfg_reg_t;

  typedef enum logic {
    FACING_SPHERICAL   = 1'b0,
    FACING_CYLINDRICAL = 1'b1
  } facing_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] right_x;
    logic signed [OFF_W-1:0] right_y;
    logic signed [OFF_W-1:0] right_z;
    logic signed [OFF_W-1:0] up_x;
    logic signed [OFF_W-1:0] up_y;
    logic signed [OFF_W-1:0] up_z;
  } offset_t;

  typedef struct packed {
    logic right_pos;
    logic up_pos;
  } corner_sel_t;

endpackage

// ----- hdl/bce_offset_calc.sv -----
`timescale 1ns / 1ps
module bce_offset_calc (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bce_pkg::CFG_DATA_W-1:0] cfg_data,
  output bce_pkg::offset_t               offsets
);
  import bce_pkg::*;

  logic signed [VEC_W-1:0] right_x;
  logic signed [VEC_W-1:0] right_y;
  logic signed [VEC_W-1:0] right_z;
  logic signed [VEC_W-1:0] up_x;
  logic signed [VEC_W-1:0] up_y;
  logic signed [VEC_W-1:0] up_z;
  logic [2*SIZE_W-1:0]     quad_size;
  facing_t                 facing_mode;
  offset_t                 offsets_next;
  logic [SIZE_W-1:0]       width;
  logic [SIZE_W-1:0]       height;

  // Vector times size, halved, rounded half up to Q16.16 (a floor of n / 128).
  function automatic logic signed [OFF_W-1:0] scale_half(
    input logic signed [VEC_W-1:0] vec,
    input logic [SIZE_W-1:0]       size
  );
    logic signed [SUM_W-1:0] n;
    n = SUM_W'(vec) * $signed({{(SUM_W-SIZE_W){1'b0}}, size}) + SUM_W'(64);
    return n[OFF_W+6:7];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      right_x     <= RIGHT_X_RST;
      right_y     <= RIGHT_Y_RST;
      right_z     <= RIGHT_Z_RST;
      up_x        <= UP_X_RST;
      up_y        <= UP_Y_RST;
      up_z        <= UP_Z_RST;
      quad_size   <= QUAD_SIZE_RST;
      facing_mode <= FACING_SPHERICAL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RIGHT_X:     right_x     <= cfg_data[VEC_W-1:0];
        REG_RIGHT_Y:     right_y     <= cfg_data[VEC_W-1:0];
        REG_RIGHT_Z:     right_z     <= cfg_data[VEC_W-1:0];
        REG_UP_X:        up_x        <= cfg_data[VEC_W-1:0];
        REG_UP_Y:        up_y        <= cfg_data[VEC_W-1:0];
        REG_UP_Z:        up_z        <= cfg_data[VEC_W-1:0];
        REG_QUAD_SIZE:   quad_size   <= cfg_data[2*SIZE_W-1:0];
        REG_FACING_MODE: facing_mode <= facing_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  assign width  = quad_size[SIZE_W-1:0];
  assign height = quad_size[2*SIZE_W-1:SIZE_W];

  always_comb begin
    offsets_next.right_x = scale_half(right_x, width);
    offsets_next.right_y = scale_half(right_y, width);
    offsets_next.right_z = scale_half(right_z, width);
    offsets_next.up_y    = scale_half(up_y, height);
    if (facing_mode == FACING_CYLINDRICAL) begin
      offsets_next.up_x = '0;
      offsets_next.up_z = '0;
    end else begin
      offsets_next.up_x = scale_half(up_x, height);
      offsets_next.up_z = scale_half(up_z, height);
    end
  end

  // Offsets are registered from the configuration registers; the input stage covers that delay.
  always_ff @(posedge clk) begin
    offsets <= offsets_next;
  end

endmodule

// ----- hdl/bce_axis_sum.sv -----
`timescale 1ns / 1ps
module bce_axis_sum (
  input  logic signed [bce_pkg::COORD_W-1:0] center,
  input  logic signed [bce_pkg::OFF_W-1:0]   up_off,
  input  logic signed [bce_pkg::OFF_W-1:0]   right_off,
  input  bce_pkg::corner_sel_t               sel,
  output logic signed [bce_pkg::COORD_W-1:0] pos,
  output logic                               clip
);
  import bce_pkg::*;

  logic signed [SUM_W-1:0] up_term;
  logic signed [SUM_W-1:0] right_term;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    up_term    = sel.up_pos    ? SUM_W'(up_off)    : -SUM_W'(up_off);
    right_term = sel.right_pos ? SUM_W'(right_off) : -SUM_W'(right_off);
    sum        = SUM_W'(center) + up_term + right_term;
    clip       = (sum[SUM_W-1:COORD_W-1] != '0) && (sum[SUM_W-1:COORD_W-1] != '1);
    if (!clip) begin
      pos = sum[COORD_W-1:0];
    end else if (sum[SUM_W-1]) begin
      pos = COORD_MIN;
    end else begin
      pos = COORD_MAX;
    end
  end

endmodule

// ----- hdl/billboard_corner_expander.sv -----
`timescale 1ns / 1ps
// Expands billboard centre vertices into camera-facing quad corners, one result per input
// transfer, at a sustained rate of one vertex per clock while m_tready stays high, through
// an input register and then a result register. Corner offsets are precomputed from the
// configuration by six parallel multipliers into registers, so each vertex only needs one
// three-way add and a saturation per axis. The corner counter cycles -up-right, -up+right,
// +up-right, +up+right and returns to the first corner after a transfer with s_tlast set.
// Write the configuration only while no vertex is in flight.
module billboard_corner_expander (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bce_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata fields from bit 0: center_x[31:0], center_y[63:32], center_z[95:64].
  input  logic [bce_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata fields from bit 0: pos_x[31:0], pos_y[63:32], pos_z[95:64].
  output logic [bce_pkg::M_DATA_W-1:0]   m_tdata,
  // m_tuser fields from bit 0: corner_index[1:0], clipped[2].
  output logic [bce_pkg::M_USER_W-1:0]   m_tuser
);
  import bce_pkg::*;

  offset_t                   offsets;
  logic [CORNER_W-1:0]       corner_count;
  logic [CORNER_W-1:0]       corner_count_next;
  logic                      in_valid;
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;
  logic signed [COORD_W-1:0] in_z;
  logic [CORNER_W-1:0]       in_corner;
  corner_sel_t               sel;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic                      clip_x;
  logic                      clip_y;
  logic                      clip_z;
  logic                      out_free;
  logic                      in_move;
  logic                      accept;

  assign cfg_ready = 1'b1;

  bce_offset_calc u_offset_calc (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .offsets   (offsets)
  );

  assign out_free = !m_tvalid || m_tready;
  assign in_move  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  assign corner_count_next = s_tlast ? '0 : corner_count + CORNER_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= '0;
      in_valid     <= 1'b0;
    end else begin
      if (accept) begin
        corner_count <= corner_count_next;
      end
      if (accept) begin
        in_valid <= 1'b1;
      end else if (in_move) begin
        in_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_x      <= s_tdata[COORD_W-1:0];
      in_y      <= s_tdata[2*COORD_W-1:COORD_W];
      in_z      <= s_tdata[3*COORD_W-1:2*COORD_W];
      in_corner <= corner_count;
    end
  end

  assign sel.right_pos = in_corner[0];
  assign sel.up_pos    = in_corner[1];

  bce_axis_sum u_sum_x (
    .center    (in_x),
    .up_off    (offsets.up_x),
    .right_off (offsets.right_x),
    .sel       (sel),
    .pos       (pos_x),
    .clip      (clip_x)
  );

  bce_axis_sum u_sum_y (
    .center    (in_y),
    .up_off    (offsets.up_y),
    .right_off (offsets.right_y),
    .sel       (sel),
    .pos       (pos_y),
    .clip      (clip_y)
  );

  bce_axis_sum u_sum_z (
    .center    (in_z),
    .up_off    (offsets.up_z),
    .right_off (offsets.right_z),
    .sel       (sel),
    .pos       (pos_z),
    .clip      (clip_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move) begin
      m_tdata <= {pos_z, pos_y, pos_x};
      m_tuser <= {clip_x || clip_y || clip_z, in_corner};
    end
  end

`include "billboard_corner_expander_defines.svh"

  `BCE_ASSERT_NEXT(a_group_restart, accept && s_tlast, corner_count == '0)
  `BCE_ASSERT_NEXT(a_corner_advance, accept && !s_tlast, corner_count == $past(corner_count) + CORNER_W'(1))
  `BCE_ASSERT(a_clip_saturated, !(m_tvalid && m_tuser[CORNER_W]) || m_tdata[COORD_W-1:0] == COORD_MAX || m_tdata[COORD_W-1:0] == COORD_MIN || m_tdata[2*COORD_W-1:COORD_W] == COORD_MAX || m_tdata[2*COORD_W-1:COORD_W] == COORD_MIN || m_tdata[3*COORD_W-1:2*COORD_W] == COORD_MAX || m_tdata[3*COORD_W-1:2*COORD_W] == COORD_MIN)
  `BCE_ASSERT_NEXT(a_no_output_without_input, !in_valid && !m_tvalid, !m_tvalid)

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import bce_pkg::*;

  localparam int CLK_HALF_NS = 5;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_PHASES = 8;
  localparam int RANDOM_VERTICES = 950;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int AXIS_Y = 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 8'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST = 8'hFF;
  localparam logic [COORD_W-1:0] C_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [S_DATA_W-1:0] centre;
    logic                last;
  } centre_vertex_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] pos;
    logic [CORNER_W-1:0]     corner;
    logic                    clipped;
  } quad_corner_t;

  typedef struct packed {
    logic                clipped;
    logic [CORNER_W-1:0] corner;
  } corner_tag_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic cfg_ready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  // Copy of the camera setup as the block should hold it.
  logic signed [VEC_W-1:0] cam_vec [6];
  logic [2*SIZE_W-1:0] quad_size = QUAD_SIZE_RST;
  facing_t facing = FACING_SPHERICAL;
  logic [CORNER_W-1:0] corner_count = '0;

  centre_vertex_t pending_vertices[$];
  quad_corner_t expected_corners[$];
  int mismatch_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  logic long_hold_armed = 1'b0;

  billboard_corner_expander dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  function automatic longint half_scaled(input logic signed [VEC_W-1:0] vec,
                                         input logic [SIZE_W-1:0] size);
    longint n;
    n = longint'(vec) * longint'(size) + 64;
    return n >>> 7;
  endfunction

  function automatic quad_corner_t expand_corner(input logic [S_DATA_W-1:0] centre,
                                                 input logic [CORNER_W-1:0] corner);
    quad_corner_t r;
    longint right_off;
    longint up_off;
    longint sum;
    int a;
    r.corner = corner;
    r.clipped = 1'b0;
    for (a = 0; a < 3; a++) begin
      right_off = half_scaled(cam_vec[REG_RIGHT_X + a], quad_size[SIZE_W-1:0]);
      if (facing == FACING_CYLINDRICAL && a != AXIS_Y) begin
        up_off = 0;
      end else begin
        up_off = half_scaled(cam_vec[REG_UP_X + a], quad_size[2*SIZE_W-1:SIZE_W]);
      end
      sum = longint'($signed(centre[a*COORD_W +: COORD_W]))
          + (corner[1] ? up_off : -up_off) + (corner[0] ? right_off : -right_off);
      if (sum > longint'(COORD_MAX)) begin
        r.pos[a] = COORD_MAX;
        r.clipped = 1'b1;
      end else if (sum < longint'(COORD_MIN)) begin
        r.pos[a] = COORD_MIN;
        r.clipped = 1'b1;
      end else begin
        r.pos[a] = sum[COORD_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    int gap_left;
    centre_vertex_t next_vertex;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
      corner_count = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_corners.push_back(expand_corner(s_tdata, corner_count));
        corner_count = s_tlast ? '0 : corner_count + 1'b1;
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_vertices.size() > 0 && $urandom_range(0, 99) < send_gap_pct) begin
        gap_left = $urandom_range(0, 4);
        s_tvalid <= 1'b0;
      end else if (pending_vertices.size() > 0) begin
        next_vertex = pending_vertices.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= next_vertex.centre;
        s_tlast <= next_vertex.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    int stall_left;
    int hold_left;
    logic long_hold_done;
    quad_corner_t want;
    corner_tag_t tag;
    int a;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        tag = m_tuser;
        if (expected_corners.size() == 0) begin
          $display("%0t: unexpected corner transfer, expected none, actual pos %h tag %b",
                   $time, m_tdata, m_tuser);
          mismatch_count++;
        end else begin
          want = expected_corners.pop_front();
          for (a = 0; a < 3; a++) begin
            if (m_tdata[a*COORD_W +: COORD_W] !== want.pos[a]) begin
              $display("%0t: pos axis %0d expected %0d actual %0d", $time, a,
                       $signed(want.pos[a]), $signed(m_tdata[a*COORD_W +: COORD_W]));
              mismatch_count++;
            end
          end
          if (tag.corner !== want.corner) begin
            $display("%0t: corner_index expected %0d actual %0d",
                     $time, want.corner, tag.corner);
            mismatch_count++;
          end
          if (tag.clipped !== want.clipped) begin
            $display("%0t: clipped expected %0d actual %0d", $time, want.clipped, tag.clipped);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (long_hold_armed && !long_hold_done) begin
        hold_left = LONG_HOLD_CYCLES - 1;
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        stall_left = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_UP_Z) begin
      cam_vec[idx] = val[VEC_W-1:0];
    end else if (idx == REG_QUAD_SIZE) begin
      quad_size = val;
    end else if (idx == REG_FACING_MODE) begin
      facing = facing_t'(val[0]);
    end
  endtask

  task automatic push_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic last);
    centre_vertex_t v;
    v.centre = {z, y, x};
    v.last = last;
    pending_vertices.push_back(v);
  endtask

  task automatic wait_drained;
    do @(negedge clk);
    while (pending_vertices.size() != 0 || s_tvalid || expected_corners.size() != 0);
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_vec;
    logic [15:0] junk;
    junk = 16'($urandom);
    case ($urandom_range(0, 5))
      0: return {junk, 16'h7FFF};
      1: return {junk, 16'h8000};
      2: return {junk, 16'h0000};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size;
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0000_0000;
      2: return {16'($urandom), 16'h0000};
      3: return {16'h0000, 16'($urandom)};
      4: return {16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023))};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord;
    case ($urandom_range(0, 5))
      0: return C_MAX - $urandom_range(0, 32'h0200_0000);
      1: return C_MIN + $urandom_range(0, 32'h0200_0000);
      2: return $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int p;
    int r;
    int n;
    int per_phase;
    int group_len;
    cam_vec[REG_RIGHT_X] = RIGHT_X_RST;
    cam_vec[REG_RIGHT_Y] = RIGHT_Y_RST;
    cam_vec[REG_RIGHT_Z] = RIGHT_Z_RST;
    cam_vec[REG_UP_X] = UP_X_RST;
    cam_vec[REG_UP_Y] = UP_Y_RST;
    cam_vec[REG_UP_Z] = UP_Z_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setup has zero width and height, so every corner sits on its center.
    push_vertex(C_MAX, C_MIN, 32'h0, 1'b0);
    push_vertex(C_MIN, C_MAX, 32'hFFFF_FFFF, 1'b0);
    push_vertex(32'h0, 32'h0, 32'h0, 1'b0);
    push_vertex(32'h1, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1);
    wait_drained();

    write_reg(REG_RIGHT_X, 32'hA5A5_7FFF);
    write_reg(REG_RIGHT_Y, 32'h0000_8000);
    write_reg(REG_RIGHT_Z, 32'd12345);
    write_reg(REG_UP_X, 32'hFFFF_8000);
    write_reg(REG_UP_Y, 32'h0000_7FFF);
    write_reg(REG_UP_Z, 32'h0000_FFFF);
    write_reg(REG_QUAD_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_FACING_MODE, 32'hFFFF_FFFE);
    write_reg(REG_UNUSED_FIRST, 32'h0000_0001);
    write_reg(REG_UNUSED_LAST, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    push_vertex(C_MAX, C_MAX, C_MAX, 1'b0);
    push_vertex(C_MIN, C_MIN, C_MIN, 1'b0);
    push_vertex(C_MAX, C_MIN, 32'h0, 1'b0);
    push_vertex(C_MIN, C_MAX, 32'h0, 1'b0);
    push_vertex(32'h0, 32'h0, 32'h0, 1'b0);
    push_vertex(32'h0, 32'h0, 32'h0, 1'b1);
    push_vertex(32'h7FFF_0000, 32'h8001_0000, 32'h0001_0000, 1'b0);
    push_vertex(32'h0100_0000, 32'hFF00_0000, 32'h0, 1'b0);
    push_vertex(32'h7F00_0000, 32'h80FF_0000, 32'h0, 1'b1);
    push_vertex(32'h0, 32'h0, 32'h0, 1'b0);
    wait_drained();

    write_reg(REG_FACING_MODE, 32'h0000_0001);
    write_reg(REG_QUAD_SIZE, 32'h0100_0000);
    cfg_valid <= 1'b0;
    for (n = 0; n < 4; n++) push_vertex($urandom, $urandom, $urandom, n == 3);
    wait_drained();

    per_phase = RANDOM_VERTICES / RANDOM_PHASES;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      for (r = REG_RIGHT_X; r <= REG_FACING_MODE; r++) begin
        if (p == 0 || $urandom_range(0, 3) != 0) begin
          if (r == REG_QUAD_SIZE) write_reg(REG_QUAD_SIZE, pick_size());
          else if (r == REG_FACING_MODE) write_reg(REG_FACING_MODE, $urandom);
          else write_reg(r[CFG_IDX_W-1:0], pick_vec());
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, 255)), $urandom);
      end
      cfg_valid <= 1'b0;
      if (p == RANDOM_PHASES - 1 || p % 3 == 0) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_gap_pct = $urandom_range(5, 40);
        recv_stall_pct = $urandom_range(5, 40);
      end
      if (p == 1) long_hold_armed <= 1'b1;
      n = 0;
      while (n < per_phase) begin
        // Mostly whole quads; now and then a short or long group.
        group_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : 4;
        for (r = 0; r < group_len; r++) begin
          push_vertex(pick_coord(), pick_coord(), pick_coord(), r == group_len - 1);
        end
        n += group_len;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_corners.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
